FILE: hdl/indexed_max_priority_queue_assert.svh
// Assertion macros for the indexed max priority queue.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef INDEXED_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define IMXPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define IMXPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hdl/imxpq_pkg.sv
// Shared types and constants for the indexed max priority queue.
// No dependencies.
package imxpq_pkg;

    localparam int INDEX_COUNT_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET     = 3'd0,
        MODE_ERASE   = 3'd1,
        MODE_ADD     = 3'd2,
        MODE_GET     = 3'd3,
        MODE_EXTRACT = 3'd4,
        MODE_CLEAR   = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

endpackage

FILE: hdl/indexed_max_priority_queue.sv
// Indexed max priority queue: a table of INDEX_COUNT signed entries, each with a present
// mark, held in one RAM word per index and worked by a small sequencer. Set, erase and add
// are a read-modify-write. Get and extract scan every entry through one comparator, one
// RAM read per cycle. Clear writes every word once. After reset a clearing pass runs with
// s_tready low. A finished result waits in the output register while the next transfer is
// taken; ties for the maximum go to the larger index.
// Depends on imxpq_pkg, imxpq_ram and indexed_max_priority_queue_assert.svh.
`include "indexed_max_priority_queue_assert.svh"

module indexed_max_priority_queue #(
    parameter int INDEX_COUNT = imxpq_pkg::INDEX_COUNT_DEF,
    parameter int VALUE_WIDTH = imxpq_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, from bit 0: index[7:0], value[39:8], zero fill[47:40]
    input  logic [47:0] s_tdata,
    // s_tuser: mode[2:0]
    input  logic [2:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata, from bit 0: status[1:0], max_index[9:2], max_value[41:10], zero fill[47:42]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int AW = $clog2(INDEX_COUNT);
    localparam int IW = imxpq_pkg::INDEX_W;
    localparam int DW = imxpq_pkg::DATA_W;
    localparam int CW = ((AW > IW) ? AW : IW) + 1;
    localparam int XW = (VALUE_WIDTH > DW) ? VALUE_WIDTH : DW;
    localparam int WW = VALUE_WIDTH + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SCAN_END,
        ST_DONE
    } state_t;

    state_t                        state_reg, state_next;
    imxpq_pkg::mode_t              mode_reg, mode_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic                          in_range_reg, in_range_next;
    logic signed [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic                          clr_rsp_reg, clr_rsp_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;
    logic                          found_reg, found_next;
    logic signed [VALUE_WIDTH-1:0] best_val_reg, best_val_next;
    logic [AW-1:0]                 best_idx_reg, best_idx_next;
    imxpq_pkg::status_t            res_status_reg, res_status_next;
    logic [IW-1:0]                 res_index_reg, res_index_next;
    logic [DW-1:0]                 res_value_reg, res_value_next;
    logic                          m_valid_reg, m_valid_next;
    imxpq_pkg::status_t            m_status_reg, m_status_next;
    logic [IW-1:0]                 m_index_reg, m_index_next;
    logic [DW-1:0]                 m_value_reg, m_value_next;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [WW-1:0]                 ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [WW-1:0]                 ram_rdata;

    logic signed [DW-1:0]          in_value;
    logic signed [XW-1:0]          in_ext;
    logic [CW-1:0]                 in_idx_ext;
    logic                          rd_present;
    logic signed [VALUE_WIDTH-1:0] rd_val;
    logic [VALUE_WIDTH-1:0]        add_base;
    logic signed [XW-1:0]          best_ext;
    logic [CW-1:0]                 best_idx_ext;
    logic                          cnt_last;

    imxpq_ram #(
        .WIDTH (WW),
        .DEPTH (INDEX_COUNT)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign in_value     = signed'(s_tdata[39:8]);
    assign in_ext       = XW'(in_value);
    assign in_idx_ext   = CW'(s_tdata[7:0]);
    assign rd_present   = ram_rdata[VALUE_WIDTH];
    assign rd_val       = signed'(ram_rdata[VALUE_WIDTH-1:0]);
    assign add_base     = rd_present ? ram_rdata[VALUE_WIDTH-1:0] : '0;
    assign best_ext     = XW'(best_val_reg);
    assign best_idx_ext = CW'(best_idx_reg);
    assign cnt_last     = (cnt_reg == AW'(INDEX_COUNT - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_value_reg, m_index_reg, m_status_reg};

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        in_range_next   = in_range_reg;
        value_next      = value_reg;
        cnt_next        = cnt_reg;
        clr_rsp_next    = clr_rsp_reg;
        rd_vld_next     = rd_vld_reg;
        rd_addr_next    = rd_addr_reg;
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_value_next    = m_value_reg;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = cnt_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        // Shared comparator: fold the entry read last cycle into the running maximum
        if ((state_reg == ST_SCAN || state_reg == ST_SCAN_LAST) && rd_vld_reg && rd_present) begin
            if (!found_reg || rd_val >= best_val_reg) begin
                found_next    = 1'b1;
                best_val_next = rd_val;
                best_idx_next = rd_addr_reg;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (cnt_last) begin
                    cnt_next     = '0;
                    clr_rsp_next = 1'b0;
                    state_next   = clr_rsp_reg ? ST_DONE : ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = imxpq_pkg::mode_t'(s_tuser);
                    addr_next       = in_idx_ext[AW-1:0];
                    in_range_next   = (in_idx_ext < CW'(INDEX_COUNT));
                    value_next      = in_ext[VALUE_WIDTH-1:0];
                    res_status_next = imxpq_pkg::STATUS_OK;
                    res_index_next  = '0;
                    res_value_next  = '0;
                    ram_re          = 1'b1;
                    ram_raddr       = in_idx_ext[AW-1:0];
                    case (imxpq_pkg::mode_t'(s_tuser))
                        imxpq_pkg::MODE_SET,
                        imxpq_pkg::MODE_ERASE,
                        imxpq_pkg::MODE_ADD: begin
                            state_next = ST_RMW;
                        end
                        imxpq_pkg::MODE_GET,
                        imxpq_pkg::MODE_EXTRACT: begin
                            cnt_next    = '0;
                            found_next  = 1'b0;
                            rd_vld_next = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        imxpq_pkg::MODE_CLEAR: begin
                            cnt_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                ram_waddr  = addr_reg;
                state_next = ST_DONE;
                if (!in_range_reg) begin
                    res_status_next = imxpq_pkg::STATUS_ABSENT;
                end else begin
                    case (mode_reg)
                        imxpq_pkg::MODE_SET: begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, value_reg};
                        end
                        imxpq_pkg::MODE_ERASE: begin
                            if (rd_present) begin
                                ram_we = 1'b1;
                            end else begin
                                res_status_next = imxpq_pkg::STATUS_ABSENT;
                            end
                        end
                        imxpq_pkg::MODE_ADD: begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, add_base + value_reg};
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                ram_re       = 1'b1;
                rd_vld_next  = 1'b1;
                rd_addr_next = cnt_reg;
                if (cnt_last) begin
                    cnt_next   = '0;
                    state_next = ST_SCAN_LAST;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN_LAST: begin
                rd_vld_next = 1'b0;
                state_next  = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                state_next = ST_DONE;
                if (found_reg) begin
                    res_index_next = best_idx_ext[IW-1:0];
                    res_value_next = best_ext[DW-1:0];
                    if (mode_reg == imxpq_pkg::MODE_EXTRACT) begin
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                    end
                end else begin
                    res_status_next = imxpq_pkg::STATUS_EMPTY;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    m_value_next  = res_value_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            clr_rsp_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_rsp_reg  <= clr_rsp_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        in_range_reg   <= in_range_next;
        value_reg      <= value_next;
        rd_addr_reg    <= rd_addr_next;
        best_val_reg   <= best_val_next;
        best_idx_reg   <= best_idx_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_value_reg    <= m_value_next;
    end

    `IMXPQ_ASSERT(a_one_item_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "accepted a second item back to back")
    `IMXPQ_ASSERT(a_result_from_done, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE), "result appeared outside the done step")
    `IMXPQ_ASSERT(a_empty_result_zero, (m_valid_reg && m_status_reg == imxpq_pkg::STATUS_EMPTY) |-> (m_index_reg == '0 && m_value_reg == '0), "empty result carries data")
    `IMXPQ_ASSERT_ALWAYS(a_no_write_when_idle, (ram_we && aresetn) |-> (state_reg != ST_IDLE && state_reg != ST_DONE), "table written while idle")

endmodule

FILE: hdl/imxpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module imxpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
